/* hdl/bmpd_pkg.sv */
// Shared types, codes and constants of the BMP pixel stream decoder.
`default_nettype none
package bmpd_pkg;
	localparam int MAX_WIDTH_DEF     = 4096;
	localparam int MAX_HEIGHT_DEF    = 4096;
	localparam int PALETTE_DEPTH     = 256;
	localparam int PAL_AW            = $clog2(PALETTE_DEPTH);
	localparam int QUEUE_DEPTH       = 4;
	localparam logic [15:0] BMP_MAGIC = 16'h4d42;
	localparam logic [31:0] HEADER_BYTES = 32'd54;
	localparam logic [32:0] PAL_START_BASE = 33'd14;

	localparam logic [1:0] ST_PIXEL  = 2'd0;
	localparam logic [1:0] ST_MAGIC  = 2'd1;
	localparam logic [1:0] ST_COMP   = 2'd2;
	localparam logic [1:0] ST_FORMAT = 2'd3;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       first_byte;
	} byte_in_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [1:0]  status;
		logic        last_pixel;
	} pixel_out_t;

	typedef struct packed {
		logic              wr_en;
		logic [PAL_AW-1:0] wr_addr;
		logic [1:0]        wr_lane;
		logic [7:0]        wr_data;
		logic              res_en;
		logic              lookup;
		logic [23:0]       rgb;
		logic [12:0]       width;
		logic [12:0]       height;
		logic [1:0]        status;
		logic              last;
	} op_t;
endpackage
`default_nettype wire

/* hdl/bmpd_front.sv */
// Header parser and byte classifier that turns file bytes into palette writes and results.
`default_nettype none
module bmpd_front #(
	parameter int MAX_WIDTH  = bmpd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bmpd_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              src_valid,
	output logic                   src_stall,
	input  wire bmpd_pkg::byte_in_t src_data,
	output logic                   op_push,
	output bmpd_pkg::op_t          op_data,
	input  wire logic              op_full
);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 1);
	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_SKIP   = 3'd1;
	localparam logic [2:0] PH_PIXEL  = 3'd2;
	localparam logic [2:0] PH_PAD    = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;
	localparam logic [32:0] PAL_START_BASE_C = bmpd_pkg::PAL_START_BASE;

	logic [31:0] pos_q, pdo_q, ihs_q, wst_q, hst_q, comp_q, colors_q;
	logic [15:0] bpp_q;
	logic [7:0]  magic_lo_q;
	logic [2:0]  phase_q, phase_c, phase_n;
	logic [2:0]  cpp_q, cpp_n;
	logic [1:0]  pad_row_q, pad_row_n, pad_q, pad_n, comp_cnt_q, comp_cnt_n;
	logic [23:0] part_q, part_n, part_ins;
	logic [CW-1:0] col_q, col_n, col_inc;
	logic [RW-1:0] row_q, row_n, row_inc;
	logic [31:0] pos_c;
	logic [32:0] pal_diff;
	logic [7:0]  b;
	logic        accept, res_en, lookup, last;
	logic [1:0]  status;
	logic [23:0] rgb;
	logic        dim_bad;
	logic [2:0]  cpp_d;
	logic [1:0]  rowmod;

	assign b      = src_data.file_byte;
	assign accept = src_valid && !op_full;
	assign src_stall = op_full;
	assign phase_c = src_data.first_byte ? PH_HEADER : phase_q;
	assign pos_c   = src_data.first_byte ? 32'd0 : pos_q;
	assign pal_diff = {1'b0, pos_c} - (PAL_START_BASE_C + {1'b0, ihs_q});

	assign col_inc = col_q + CW'(1);
	assign row_inc = row_q + RW'(1);

	always_comb begin
		dim_bad = wst_q[31] || hst_q[31] || (wst_q > 32'(MAX_WIDTH)) ||
			(hst_q > 32'(MAX_HEIGHT));
		if (bpp_q == 16'd24)
			cpp_d = 3'd3;
		else if (bpp_q == 16'd32)
			cpp_d = 3'd4;
		else if (bpp_q == 16'd8 && colors_q == 32'd256)
			cpp_d = 3'd1;
		else
			cpp_d = 3'd0;
		case (cpp_d)
			3'd1:    rowmod = wst_q[1:0];
			3'd3:    rowmod = 2'(wst_q[1:0] * 2'd3);
			default: rowmod = 2'd0;
		endcase
	end

	always_comb begin
		phase_n = phase_c;
		cpp_n = cpp_q;
		pad_row_n = pad_row_q;
		pad_n = pad_q;
		comp_cnt_n = comp_cnt_q;
		part_n = part_q;
		col_n = col_q;
		row_n = row_q;
		res_en = 1'b0;
		lookup = 1'b0;
		last = 1'b0;
		status = bmpd_pkg::ST_PIXEL;
		rgb = 24'd0;
		part_ins = part_q;
		case (comp_cnt_q)
			2'd0:    part_ins[7:0] = b;
			2'd1:    part_ins[15:8] = b;
			2'd2:    part_ins[23:16] = b;
			default: part_ins = part_q;
		endcase
		unique case (phase_c) inside
			PH_HEADER: begin
				if (pos_c == 32'd1 && {b, magic_lo_q} != bmpd_pkg::BMP_MAGIC) begin
					res_en = 1'b1;
					status = bmpd_pkg::ST_MAGIC;
					phase_n = PH_DONE;
				end else if (pos_c == bmpd_pkg::HEADER_BYTES - 32'd1) begin
					phase_n = PH_DONE;
					if (dim_bad || cpp_d == 3'd0) begin
						res_en = 1'b1;
						status = bmpd_pkg::ST_FORMAT;
					end else if (comp_q != 32'd0 && cpp_d != 3'd4) begin
						res_en = 1'b1;
						status = bmpd_pkg::ST_COMP;
					end else if (pdo_q < bmpd_pkg::HEADER_BYTES) begin
						res_en = 1'b1;
						status = bmpd_pkg::ST_FORMAT;
					end else if (wst_q != 32'd0 && hst_q != 32'd0) begin
						phase_n = PH_SKIP;
						cpp_n = cpp_d;
						pad_row_n = 2'(-rowmod);
						col_n = '0;
						row_n = '0;
						comp_cnt_n = 2'd0;
						part_n = 24'd0;
					end
				end
			end
			PH_SKIP, PH_PIXEL: begin
				if (phase_c == PH_PIXEL || pos_c == pdo_q) begin
					phase_n = PH_PIXEL;
					if (cpp_q == 3'd1) begin
						res_en = 1'b1;
						lookup = 1'b1;
						rgb = {16'd0, b};
					end else if ({1'b0, comp_cnt_q} + 3'd1 < cpp_q) begin
						part_n = part_ins;
						comp_cnt_n = comp_cnt_q + 2'd1;
					end else begin
						res_en = 1'b1;
						rgb = part_ins;
						part_n = 24'd0;
						comp_cnt_n = 2'd0;
					end
					if (res_en) begin
						last = (32'(col_inc) == wst_q) && (32'(row_inc) == hst_q);
						col_n = col_inc;
						if (32'(col_inc) >= wst_q) begin
							col_n = '0;
							row_n = row_inc;
							if (32'(row_inc) >= hst_q)
								phase_n = PH_DONE;
							else if (pad_row_q != 2'd0) begin
								pad_n = pad_row_q;
								phase_n = PH_PAD;
							end
						end
					end
				end
			end
			PH_PAD: begin
				if (pad_q != 2'd0)
					pad_n = pad_q - 2'd1;
				if (pad_q <= 2'd1)
					phase_n = PH_PIXEL;
			end
			default: phase_n = phase_c;
		endcase
	end

	always_comb begin
		op_data = '0;
		op_data.wr_en = (pos_c >= 32'd18) && !pal_diff[32] && (pal_diff[31:10] == '0) &&
			(pal_diff[1:0] != 2'd3);
		op_data.wr_addr = pal_diff[9:2];
		op_data.wr_lane = pal_diff[1:0];
		op_data.wr_data = b;
		op_data.res_en = res_en;
		op_data.lookup = lookup;
		op_data.rgb = rgb;
		op_data.status = status;
		op_data.last = last;
		op_data.width = (status == bmpd_pkg::ST_PIXEL) ? wst_q[12:0] : 13'd0;
		op_data.height = (status == bmpd_pkg::ST_PIXEL) ? hst_q[12:0] : 13'd0;
		op_push = accept && (op_data.wr_en || res_en);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; pdo_q <= '0; ihs_q <= '0; wst_q <= '0; hst_q <= '0;
			comp_q <= '0; colors_q <= '0; bpp_q <= '0; magic_lo_q <= '0;
			phase_q <= PH_HEADER; cpp_q <= '0; pad_row_q <= '0; pad_q <= '0;
			comp_cnt_q <= '0; part_q <= '0; col_q <= '0; row_q <= '0;
		end else if (accept) begin
			if (src_data.first_byte) begin
				pdo_q <= '0; ihs_q <= '0; wst_q <= '0; hst_q <= '0;
				comp_q <= '0; colors_q <= '0; bpp_q <= '0;
			end
			pos_q <= (pos_c == 32'hFFFF_FFFF) ? pos_c : pos_c + 32'd1;
			phase_q <= phase_n;
			cpp_q <= cpp_n;
			pad_row_q <= pad_row_n;
			pad_q <= pad_n;
			comp_cnt_q <= comp_cnt_n;
			part_q <= part_n;
			col_q <= col_n;
			row_q <= row_n;
			if (phase_c == PH_HEADER && pos_c[31:6] == '0) begin
				case (pos_c[5:0])
					6'd0:  magic_lo_q <= b;
					6'd10: pdo_q[7:0] <= b;
					6'd11: pdo_q[15:8] <= b;
					6'd12: pdo_q[23:16] <= b;
					6'd13: pdo_q[31:24] <= b;
					6'd14: ihs_q[7:0] <= b;
					6'd15: ihs_q[15:8] <= b;
					6'd16: ihs_q[23:16] <= b;
					6'd17: ihs_q[31:24] <= b;
					6'd18: wst_q[7:0] <= b;
					6'd19: wst_q[15:8] <= b;
					6'd20: wst_q[23:16] <= b;
					6'd21: wst_q[31:24] <= b;
					6'd22: hst_q[7:0] <= b;
					6'd23: hst_q[15:8] <= b;
					6'd24: hst_q[23:16] <= b;
					6'd25: hst_q[31:24] <= b;
					6'd28: bpp_q[7:0] <= b;
					6'd29: bpp_q[15:8] <= b;
					6'd30: comp_q[7:0] <= b;
					6'd31: comp_q[15:8] <= b;
					6'd32: comp_q[23:16] <= b;
					6'd33: comp_q[31:24] <= b;
					6'd46: colors_q[7:0] <= b;
					6'd47: colors_q[15:8] <= b;
					6'd48: colors_q[23:16] <= b;
					6'd49: colors_q[31:24] <= b;
					default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

/* hdl/bmpd_queue.sv */
// Short queue of decoded operations between the parser and the pixel output stage.
`default_nettype none
module bmpd_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire bmpd_pkg::op_t push_data,
	output logic               full,
	input  wire logic          pop,
	output logic               avail,
	output bmpd_pkg::op_t      head
);
	localparam int AW = $clog2(bmpd_pkg::QUEUE_DEPTH);

	bmpd_pkg::op_t slot_q [bmpd_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign full  = cnt_q == (AW + 1)'(bmpd_pkg::QUEUE_DEPTH);
	assign avail = cnt_q != '0;
	assign head  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + AW'(1);
			if (pop)
				rp_q <= rp_q + AW'(1);
			cnt_q <= cnt_q + (AW + 1)'(push) - (AW + 1)'(pop);
		end
	end
endmodule
`default_nettype wire

/* hdl/bmpd_back.sv */
// Palette memory, colour lookup and registered result output.
`default_nettype none
module bmpd_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           op_avail,
	input  wire bmpd_pkg::op_t  op_head,
	output logic                op_pop,
	output logic                pix_valid,
	input  wire logic           pix_stall,
	output bmpd_pkg::pixel_out_t pix_data
);
	logic [23:0] pal_mem [bmpd_pkg::PALETTE_DEPTH];
	logic [23:0] rd_s1;
	logic [23:0] rgb_s1;
	bmpd_pkg::op_t op_s1;
	logic        valid_s1, out_ready, s1_ready;

	assign out_ready = !pix_valid || !pix_stall;
	assign s1_ready  = !valid_s1 || out_ready;
	assign op_pop    = op_avail && s1_ready;

	always_comb begin
		rgb_s1 = rd_s1;
		if (op_s1.wr_en && op_s1.wr_addr == op_s1.rgb[bmpd_pkg::PAL_AW-1:0])
			rgb_s1[op_s1.wr_lane*8 +: 8] = op_s1.wr_data;
	end

	always_ff @(posedge clk) begin
		if (op_pop && op_head.wr_en)
			pal_mem[op_head.wr_addr][op_head.wr_lane*8 +: 8] <= op_head.wr_data;
		if (op_pop && op_head.lookup)
			rd_s1 <= pal_mem[op_head.rgb[bmpd_pkg::PAL_AW-1:0]];
		if (op_pop)
			op_s1 <= op_head;
		if (valid_s1 && out_ready) begin
			{pix_data.red, pix_data.green, pix_data.blue} <= op_s1.lookup ? rgb_s1 : op_s1.rgb;
			pix_data.image_width <= op_s1.width;
			pix_data.image_height <= op_s1.height;
			pix_data.status <= op_s1.status;
			pix_data.last_pixel <= op_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pix_valid <= 1'b0;
		end else begin
			if (s1_ready)
				valid_s1 <= op_pop && op_head.res_en;
			if (out_ready)
				pix_valid <= valid_s1;
		end
	end
endmodule
`default_nettype wire

/* hdl/bmp_pixel_stream_decoder.sv */
// Top level of the BMP pixel stream decoder.
// The block takes one file byte per transaction and can accept a byte in every cycle while
// the operation queue is not full; each pixel or error result passes through that queue,
// the palette read register and the output register. A stalled output fills the four-entry
// queue before the byte input stalls.
`default_nettype none
module bmp_pixel_stream_decoder #(
	parameter int MAX_WIDTH  = bmpd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bmpd_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 src_valid,
	output logic                      src_stall,
	input  wire bmpd_pkg::byte_in_t   src_data,
	output logic                      pix_valid,
	input  wire logic                 pix_stall,
	output bmpd_pkg::pixel_out_t      pix_data
);
	logic          push, full, pop, avail;
	bmpd_pkg::op_t push_data, head;

	bmpd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk(clk), .arst_n(arst_n), .src_valid(src_valid), .src_stall(src_stall),
		.src_data(src_data), .op_push(push), .op_data(push_data), .op_full(full)
	);

	bmpd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data), .full(full),
		.pop(pop), .avail(avail), .head(head)
	);

	bmpd_back u_back (
		.clk(clk), .arst_n(arst_n), .op_avail(avail), .op_head(head), .op_pop(pop),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix_data(pix_data)
	);
endmodule
`default_nettype wire
